// File: design/bpc_pkg.sv
package bpc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_OSS   = 3'd3;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Compensation constants
    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] X3_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] P_COEF_SQ  = 32'd3038;
    localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_BIAS     = 32'd3791;

    typedef logic [31:0] word_t;

    function automatic word_t sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic word_t zx16(input logic [15:0] v);
        return {16'd0, v};
    endfunction

    function automatic word_t mul32(input word_t a, input word_t b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

endpackage

// File: design/bpc_div.sv
module bpc_div #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [W-1:0]  quo,
    output logic [SW-1:0] side_out
);

    // One quotient bit per stage, restoring, unsigned
    logic [W-1:0]  rem_reg  [W];
    logic [W-1:0]  num_reg  [W];
    logic [W-1:0]  den_reg  [W];
    logic [W-1:0]  quo_reg  [W];
    logic [SW-1:0] side_reg [W];
    logic          vld_reg  [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0]  prev_rem;
        logic [W-1:0]  prev_num;
        logic [W-1:0]  prev_den;
        logic [W-1:0]  prev_quo;
        logic [SW-1:0] prev_side;
        logic          prev_vld;
        logic [W:0]    trial;
        logic [W:0]    diff;
        logic          ge;
        logic [W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign prev_rem  = '0;
            assign prev_num  = num;
            assign prev_den  = den;
            assign prev_quo  = '0;
            assign prev_side = side_in;
            assign prev_vld  = in_vld;
        end
        else begin : g_rest
            assign prev_rem  = rem_reg[i-1];
            assign prev_num  = num_reg[i-1];
            assign prev_den  = den_reg[i-1];
            assign prev_quo  = quo_reg[i-1];
            assign prev_side = side_reg[i-1];
            assign prev_vld  = vld_reg[i-1];
        end

        always_comb
        begin
            trial    = {prev_rem, prev_num[W-1]};
            diff     = trial - {1'b0, prev_den};
            ge       = (trial >= {1'b0, prev_den});
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= prev_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                num_reg[i]  <= {prev_num[W-2:0], 1'b0};
                den_reg[i]  <= prev_den;
                quo_reg[i]  <= {prev_quo[W-2:0], ge};
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_vld  = vld_reg[W-1];
    assign quo      = quo_reg[W-1];
    assign side_out = side_reg[W-1];

endmodule

// File: design/barometric_pressure_compensation_core.sv
// Barometric pressure compensation core.
//
// Input channel: raw_temp and raw_press with in_valid / in_stall. A request
// is taken at a rising edge with in_valid high and in_stall low.
// Output channel: pressure_pa and div_error with out_valid / out_stall.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_addr
// (0 cal_word_a, 1 cal_word_b, 2 cal_word_c, 3 oversampling); other
// addresses are dropped. Write only while no request is in flight.
//
// Throughput: one request per cycle unless a stalled output holds the pipeline. The
// path runs through two 32-stage pipelined dividers (one quotient bit per
// stage) plus ten arithmetic stages.
// Reset clears all valid bits and the calibration registers to zero.
// A stall at the output freezes the whole pipeline; in_stall rises in the
// same cycle, so nothing is lost or repeated. A zero divisor raises
// div_error and forces pressure_pa to zero.
module barometric_pressure_compensation_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   raw_temp,
    input  logic [23:0]                   raw_press,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            pressure_pa,
    output logic                          div_error
);
    import bpc_pkg::*;

    localparam int DW  = 32;
    localparam int SW1 = 32 + 24 + 2;
    localparam int SW2 = 2;

    // Calibration registers
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CAL_A: cal_a_reg <= cfg_wdata;
                REG_CAL_B: cal_b_reg <= cfg_wdata;
                REG_CAL_C: cal_c_reg <= cfg_wdata[31:0];
                REG_OSS:   oss_reg   <= cfg_wdata[1:0];
                default:   ;
            endcase
        end
    end

    word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(cal_a_reg[63:48]);
    assign ac2 = sx16(cal_a_reg[47:32]);
    assign ac3 = sx16(cal_a_reg[31:16]);
    assign ac4 = zx16(cal_a_reg[15:0]);
    assign ac5 = zx16(cal_b_reg[63:48]);
    assign ac6 = zx16(cal_b_reg[47:32]);
    assign b1  = sx16(cal_b_reg[31:16]);
    assign b2  = sx16(cal_b_reg[15:0]);
    assign mc  = sx16(cal_c_reg[31:16]);
    assign md  = sx16(cal_c_reg[15:0]);

    // Global advance: the pipeline moves unless the output holds a stalled result
    logic en;
    logic out_vld_reg;
    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    // Stage 1: temperature product
    logic        s1_vld_reg;
    word_t       s1_x1_reg;
    logic [23:0] s1_up_reg;
    word_t       s1_x1_next;

    assign s1_x1_next = word_t'($signed(mul32(zx16(raw_temp) - ac6, ac5)) >>> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1_reg <= s1_x1_next;
            s1_up_reg <= raw_press;
        end
    end

    // Divider 1 setup: mc<<11 / (x1+md), signed via magnitudes
    word_t   d1_den_raw, d1_num_raw, d1_num, d1_den;
    logic    d1_zero, d1_neg;
    logic [SW1-1:0] d1_side_in, d1_side_out;
    logic    d1_vld;
    word_t   d1_quo;

    always_comb
    begin
        d1_den_raw = s1_x1_reg + md;
        d1_num_raw = mc << 11;
        d1_zero    = (d1_den_raw == '0);
        d1_neg     = d1_den_raw[31] ^ d1_num_raw[31];
        d1_num     = d1_num_raw[31] ? (~d1_num_raw + 32'd1) : d1_num_raw;
        if (d1_zero)
            d1_den = 32'd1;
        else
            d1_den = d1_den_raw[31] ? (~d1_den_raw + 32'd1) : d1_den_raw;
        d1_side_in = {s1_x1_reg, s1_up_reg, d1_zero, d1_neg};
    end

    bpc_div #(.W(DW), .SW(SW1)) u_div_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s1_vld_reg),
        .num      (d1_num),
        .den      (d1_den),
        .side_in  (d1_side_in),
        .out_vld  (d1_vld),
        .quo      (d1_quo),
        .side_out (d1_side_out)
    );

    // Stage 3: b6
    logic        s3_vld_reg, s3_err_reg;
    word_t       s3_b6_reg;
    logic [23:0] s3_up_reg;
    word_t       s3_x2;

    assign s3_x2 = d1_side_out[0] ? (~d1_quo + 32'd1) : d1_quo;

    // Stage 4: products of b6
    logic        s4_vld_reg, s4_err_reg;
    word_t       s4_sq_reg, s4_x2a_reg, s4_x1c_reg;
    logic [23:0] s4_up_reg;

    // Stage 5: products of sq
    logic        s5_vld_reg, s5_err_reg;
    word_t       s5_x1b_reg, s5_x2c_reg, s5_x2a_reg, s5_x1c_reg;
    logic [23:0] s5_up_reg;

    // Stage 6: b3 and x3
    logic        s6_vld_reg, s6_err_reg;
    word_t       s6_b3_reg, s6_x3_reg;
    logic [23:0] s6_up_reg;
    word_t       s6_tmp, s6_b3_next, s6_x3_next;

    always_comb
    begin
        s6_tmp     = (mul32(ac1, 32'd4) + s5_x1b_reg + s5_x2a_reg) << oss_reg;
        s6_tmp     = s6_tmp + 32'd2;
        s6_b3_next = word_t'($signed(s6_tmp + (s6_tmp[31] ? 32'd3 : 32'd0)) >>> 2);
        s6_x3_next = word_t'($signed(s5_x1c_reg + s5_x2c_reg + 32'd2) >>> 2);
    end

    // Stage 7: b4
    logic        s7_vld_reg, s7_err_reg;
    word_t       s7_b4_reg, s7_b3_reg;
    logic [23:0] s7_up_reg;

    // Stage 8: b7
    logic        s8_vld_reg, s8_err_reg;
    word_t       s8_b7_reg, s8_b4_reg;
    word_t       s8_up_sh;

    assign s8_up_sh = {8'd0, s7_up_reg} >> (4'd8 - {2'b00, oss_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= d1_vld;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_b6_reg  <= d1_side_out[SW1-1 -: 32] + s3_x2 - B6_OFFSET;
            s3_up_reg  <= d1_side_out[25:2];
            s3_err_reg <= d1_side_out[1];

            s4_sq_reg  <= word_t'($signed(mul32(s3_b6_reg, s3_b6_reg)) >>> 12);
            s4_x2a_reg <= word_t'($signed(mul32(ac2, s3_b6_reg)) >>> 11);
            s4_x1c_reg <= word_t'($signed(mul32(ac3, s3_b6_reg)) >>> 13);
            s4_up_reg  <= s3_up_reg;
            s4_err_reg <= s3_err_reg;

            s5_x1b_reg <= word_t'($signed(mul32(b2, s4_sq_reg)) >>> 11);
            s5_x2c_reg <= word_t'($signed(mul32(b1, s4_sq_reg)) >>> 16);
            s5_x2a_reg <= s4_x2a_reg;
            s5_x1c_reg <= s4_x1c_reg;
            s5_up_reg  <= s4_up_reg;
            s5_err_reg <= s4_err_reg;

            s6_b3_reg  <= s6_b3_next;
            s6_x3_reg  <= s6_x3_next;
            s6_up_reg  <= s5_up_reg;
            s6_err_reg <= s5_err_reg;

            s7_b4_reg  <= mul32(ac4, s6_x3_reg + X3_BIAS) >> 15;
            s7_b3_reg  <= s6_b3_reg;
            s7_up_reg  <= s6_up_reg;
            s7_err_reg <= s6_err_reg;

            s8_b7_reg  <= mul32(s8_up_sh - s7_b3_reg, B7_SCALE >> oss_reg);
            s8_b4_reg  <= s7_b4_reg;
            s8_err_reg <= s7_err_reg || (s7_b4_reg == '0);
        end
    end

    // Divider 2: unsigned p = b7*2/b4 or (b7/b4)*2
    word_t          d2_num, d2_den, d2_quo;
    logic [SW2-1:0] d2_side_out;
    logic           d2_vld;

    assign d2_num = s8_b7_reg[31] ? s8_b7_reg : {s8_b7_reg[30:0], 1'b0};
    assign d2_den = s8_err_reg ? 32'd1 : s8_b4_reg;

    bpc_div #(.W(DW), .SW(SW2)) u_div_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s8_vld_reg),
        .num      (d2_num),
        .den      (d2_den),
        .side_in  ({s8_err_reg, s8_b7_reg[31]}),
        .out_vld  (d2_vld),
        .quo      (d2_quo),
        .side_out (d2_side_out)
    );

    // Stage 10: final correction products
    logic  s10_vld_reg, s10_err_reg;
    word_t s10_p_reg, s10_tt_reg, s10_x2_reg;
    word_t s10_p, s10_t;

    assign s10_p = d2_side_out[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    assign s10_t = word_t'($signed(s10_p) >>> 8);

    // Stage 11
    logic  s11_vld_reg, s11_err_reg;
    word_t s11_p_reg, s11_x1_reg, s11_x2_reg;

    // Output register
    word_t out_p_reg;
    logic  out_err_reg;
    word_t out_p_next;

    assign out_p_next = s11_p_reg
                      + word_t'($signed(s11_x1_reg + s11_x2_reg + P_BIAS) >>> 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s10_vld_reg <= d2_vld;
            s11_vld_reg <= s10_vld_reg;
            out_vld_reg <= s11_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_p_reg   <= s10_p;
            s10_tt_reg  <= mul32(s10_t, s10_t);
            s10_x2_reg  <= word_t'($signed(mul32(P_COEF_LIN, s10_p)) >>> 16);
            s10_err_reg <= d2_side_out[1];

            s11_p_reg   <= s10_p_reg;
            s11_x1_reg  <= word_t'($signed(mul32(s10_tt_reg, P_COEF_SQ)) >>> 16);
            s11_x2_reg  <= s10_x2_reg;
            s11_err_reg <= s10_err_reg;

            out_p_reg   <= s11_err_reg ? '0 : out_p_next;
            out_err_reg <= s11_err_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign pressure_pa = $signed(out_p_reg);
    assign div_error   = out_err_reg;

    // An accepted request enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_vld_reg)
        else $error("accepted request missing from stage 1");

    // An error result always carries zero pressure
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> (pressure_pa == 0))
        else $error("error result with nonzero pressure");

    // A stalled output freezes the inner pipeline
    a_hold_inner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> ($stable(s8_b7_reg) && $stable(s8_vld_reg)
                                        && $stable(s11_p_reg)))
        else $error("pipeline moved during output stall");

    // A zero b4 is flagged on the way into the second divider
    a_b4_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s7_vld_reg && (s7_b4_reg == '0)) |=> s8_err_reg)
        else $error("zero b4 not flagged");

endmodule
